// ===== hdl/assert_macros.svh =====
// Assertion helpers, sampled on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");

`define CHK_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/isotp_pkg.sv =====
`default_nettype none
package isotp_pkg;

    localparam int MAX_MESSAGE_BYTES = 1024;
    localparam int LEN_W = 12;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_REJECT   = 3'd1;
    localparam logic [2:0] ST_FLOW     = 3'd2;
    localparam logic [2:0] ST_MORE     = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_EXPIRED  = 3'd5;

    localparam logic [1:0] REQ_FRAME   = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [1:0] CFG_REQUEST_ID    = 2'd0;
    localparam logic [1:0] CFG_ENABLED       = 2'd1;
    localparam logic [1:0] CFG_GAP_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_TOTAL_TIMEOUT = 2'd3;

    localparam logic [15:0] GAP_RESET   = 16'd1000;
    localparam logic [19:0] TOTAL_RESET = 20'd10000;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] msg_length;
        logic        msg_complete;
        logic        rx_active;
    } res_t;

    typedef struct packed {
        op_t              op;
        logic             rd_ok;
        logic [LEN_W-1:0] base;
        logic [2:0]       cnt;
        logic [6:0][7:0]  data;
        res_t             res;
    } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/isotp_ram.sv =====
`default_nettype none
module isotp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== hdl/isotp_front.sv =====
`default_nettype none
module isotp_front #(
    parameter int MAX_BYTES = isotp_pkg::MAX_MESSAGE_BYTES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [19:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,
    input  wire logic [143:0]  s_tdata,
    input  wire logic          q_full,
    output logic               q_push,
    output isotp_pkg::cmd_t    q_cmd
);
    localparam logic [isotp_pkg::LEN_W-1:0] MAX_L = isotp_pkg::LEN_W'(MAX_BYTES);

    logic [10:0] req_id_reg, req_id_next;
    logic        en_reg, en_next;
    logic [15:0] gap_reg, gap_next;
    logic [19:0] tot_reg, tot_next;
    logic [isotp_pkg::LEN_W-1:0] total_reg, total_next;
    logic [isotp_pkg::LEN_W-1:0] fill_reg, fill_next;
    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [3:0]  seq_reg, seq_next;
    logic [2:0]  fib_reg, fib_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] last_reg, last_next;

    logic [28:0] frame_id;
    logic        frame_ext, frame_rtr;
    logic [3:0]  frame_dlc;
    logic [63:0] payload;
    logic [31:0] now_ms;
    logic [9:0]  read_index;

    assign frame_id   = s_tdata[28:0];
    assign frame_ext  = s_tdata[29];
    assign frame_rtr  = s_tdata[30];
    assign frame_dlc  = s_tdata[34:31];
    assign payload    = s_tdata[98:35];
    assign now_ms     = s_tdata[130:99];
    assign read_index = s_tdata[140:131];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    function automatic logic pad_bad(input logic [63:0] p, input logic [3:0] n);
        logic bad;
        bad = 1'b0;
        for (int i = 1; i < 8; i++)
        begin
            if ((4'(i) > n) && (p[8*i +: 8] != 8'd0))
            begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

    always_comb
    begin
        logic                        expired;
        logic                        wipe;
        logic [3:0]                  kind;
        logic [3:0]                  low;
        logic [isotp_pkg::LEN_W-1:0] n12;
        logic [isotp_pkg::LEN_W-1:0] rem;
        logic [2:0]                  ncf;
        logic [2:0]                  status;

        req_id_next = req_id_reg;
        en_next     = en_reg;
        gap_next    = gap_reg;
        tot_next    = tot_reg;
        total_next  = total_reg;
        fill_next   = fill_reg;
        active_next = active_reg;
        done_next   = done_reg;
        seq_next    = seq_reg;
        fib_next    = fib_reg;
        start_next  = start_reg;
        last_next   = last_reg;

        wipe   = 1'b0;
        status = isotp_pkg::ST_NONE;
        kind   = payload[7:4];
        low    = payload[3:0];
        n12    = {low, payload[15:8]};
        rem    = (total_reg > fill_reg) ? (total_reg - fill_reg) : '0;
        ncf    = (rem > isotp_pkg::LEN_W'(7)) ? 3'd7 : rem[2:0];
        expired = active_reg &&
                  (((now_ms - last_reg) > {16'd0, gap_reg}) ||
                   ((now_ms - start_reg) > {12'd0, tot_reg}));

        q_cmd       = '0;
        q_cmd.op    = isotp_pkg::OP_NONE;

        if (q_push)
        begin
            case (s_tuser)
                isotp_pkg::REQ_FRAME:
                begin
                    if (!en_reg)
                    begin
                        status = isotp_pkg::ST_REJECT;
                    end
                    else if (frame_ext || (frame_id != {18'd0, req_id_reg}) || done_reg)
                    begin
                        status = isotp_pkg::ST_NONE;
                    end
                    else if (expired || frame_rtr || (frame_dlc != 4'd8))
                    begin
                        wipe   = 1'b1;
                        status = isotp_pkg::ST_REJECT;
                    end
                    else if (kind == 4'd0)
                    begin
                        if (active_reg || (low == 4'd0) || (low > 4'd7) || pad_bad(payload, low))
                        begin
                            wipe   = 1'b1;
                            status = isotp_pkg::ST_REJECT;
                        end
                        else
                        begin
                            q_cmd.op   = isotp_pkg::OP_WRITE;
                            q_cmd.cnt  = low[2:0];
                            q_cmd.data = payload[63:8];
                            fill_next  = isotp_pkg::LEN_W'(low);
                            total_next = isotp_pkg::LEN_W'(low);
                            done_next  = 1'b1;
                            status     = isotp_pkg::ST_COMPLETE;
                        end
                    end
                    else if (kind == 4'd1)
                    begin
                        if (active_reg || (n12 < isotp_pkg::LEN_W'(8)) || (n12 > MAX_L))
                        begin
                            wipe   = 1'b1;
                            status = isotp_pkg::ST_REJECT;
                        end
                        else
                        begin
                            q_cmd.op    = isotp_pkg::OP_WRITE;
                            q_cmd.cnt   = 3'd6;
                            q_cmd.data  = {8'd0, payload[63:16]};
                            total_next  = n12;
                            fill_next   = isotp_pkg::LEN_W'(6);
                            active_next = 1'b1;
                            start_next  = now_ms;
                            last_next   = now_ms;
                            seq_next    = 4'd1;
                            fib_next    = 3'd0;
                            status      = isotp_pkg::ST_FLOW;
                        end
                    end
                    else if ((kind != 4'd2) || !active_reg || (low != seq_reg) ||
                             pad_bad(payload, {1'b0, ncf}))
                    begin
                        wipe   = 1'b1;
                        status = isotp_pkg::ST_REJECT;
                    end
                    else
                    begin
                        q_cmd.op   = isotp_pkg::OP_WRITE;
                        q_cmd.base = fill_reg;
                        q_cmd.cnt  = ncf;
                        q_cmd.data = payload[63:8];
                        fill_next  = fill_reg + isotp_pkg::LEN_W'(ncf);
                        last_next  = now_ms;
                        seq_next   = seq_reg + 4'd1;
                        if (fill_next >= total_reg)
                        begin
                            active_next = 1'b0;
                            done_next   = 1'b1;
                            status      = isotp_pkg::ST_COMPLETE;
                        end
                        else if (fib_reg >= 3'd7)
                        begin
                            fib_next = 3'd0;
                            status   = isotp_pkg::ST_FLOW;
                        end
                        else
                        begin
                            fib_next = fib_reg + 3'd1;
                            status   = isotp_pkg::ST_MORE;
                        end
                    end
                end
                isotp_pkg::REQ_TIMEOUT:
                begin
                    if (expired)
                    begin
                        wipe   = 1'b1;
                        status = isotp_pkg::ST_EXPIRED;
                    end
                end
                isotp_pkg::REQ_RELEASE:
                begin
                    wipe = 1'b1;
                end
                default:
                begin
                    q_cmd.op    = isotp_pkg::OP_READ;
                    q_cmd.base  = isotp_pkg::LEN_W'(read_index);
                    q_cmd.rd_ok = (isotp_pkg::LEN_W'(read_index) < fill_reg) &&
                                  (isotp_pkg::LEN_W'(read_index) < MAX_L);
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                isotp_pkg::CFG_REQUEST_ID:
                begin
                    wipe        = 1'b1;
                    start_next  = '0;
                    last_next   = '0;
                    req_id_next = cfg_wdata[10:0];
                    en_next     = 1'b1;
                end
                isotp_pkg::CFG_ENABLED:       en_next  = cfg_wdata[0];
                isotp_pkg::CFG_GAP_TIMEOUT:   gap_next = cfg_wdata[15:0];
                default:                      tot_next = cfg_wdata;
            endcase
        end

        if (wipe)
        begin
            total_next  = '0;
            fill_next   = '0;
            active_next = 1'b0;
            done_next   = 1'b0;
            seq_next    = 4'd1;
            fib_next    = 3'd0;
        end

        q_cmd.res.status       = status;
        q_cmd.res.msg_length   = total_next[10:0];
        q_cmd.res.msg_complete = done_next;
        q_cmd.res.rx_active    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_id_reg <= '0;
            en_reg     <= 1'b0;
            gap_reg    <= isotp_pkg::GAP_RESET;
            tot_reg    <= isotp_pkg::TOTAL_RESET;
            total_reg  <= '0;
            fill_reg   <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            seq_reg    <= 4'd1;
            fib_reg    <= 3'd0;
            start_reg  <= '0;
            last_reg   <= '0;
        end
        else
        begin
            req_id_reg <= req_id_next;
            en_reg     <= en_next;
            gap_reg    <= gap_next;
            tot_reg    <= tot_next;
            total_reg  <= total_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
            done_reg   <= done_next;
            seq_reg    <= seq_next;
            fib_reg    <= fib_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/isotp_cmdq.sv =====
`default_nettype none
module isotp_cmdq #(
    parameter int W = $bits(isotp_pkg::cmd_t)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic              full,
    output logic              not_empty,
    output logic [W-1:0]      head
);
    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/isotp_back.sv =====
`default_nettype none
module isotp_back #(
    parameter int MAX_BYTES = isotp_pkg::MAX_MESSAGE_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  isotp_pkg::cmd_t  q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [2:0]       m_tuser,
    output logic [23:0]      m_tdata
);
    localparam int AW = $clog2(MAX_BYTES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [2:0]  user_reg, user_next;
    logic [23:0] data_reg, data_next;

    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_addr;
    logic [7:0]                  ram_wdata, ram_rdata;
    logic [isotp_pkg::LEN_W-1:0] wr_pos;
    logic                        out_free;

    assign out_free = !valid_reg || m_tready;
    assign wr_pos   = q_head.base + isotp_pkg::LEN_W'(idx_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        user_next  = user_reg;
        data_next  = data_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = q_head.base[AW-1:0];
        ram_wdata  = q_head.data[idx_reg];

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next = 3'd0;
                    if ((q_head.op == isotp_pkg::OP_WRITE) && (q_head.cnt != 3'd0))
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        ram_re     = (q_head.op == isotp_pkg::OP_READ);
                        state_next = S_EMIT;
                    end
                end
            end
            S_WRITE:
            begin
                ram_we   = 1'b1;
                ram_addr = wr_pos[AW-1:0];
                if (idx_reg == (q_head.cnt - 3'd1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    q_pop      = 1'b1;
                    valid_next = 1'b1;
                    user_next  = q_head.res.status;
                    data_next  = {3'd0, q_head.res.rx_active, q_head.res.msg_complete,
                                  q_head.res.msg_length,
                                  ((q_head.op == isotp_pkg::OP_READ) && q_head.rd_ok)
                                      ? ram_rdata : 8'd0};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    isotp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        user_reg <= user_next;
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = user_reg;
    assign m_tdata  = data_reg;
endmodule
`default_nettype wire

// ===== hdl/isotp_rx_reassembler.sv =====
// Flow: a transfer enters the command queue, the back end writes each stored byte
//   (up to 7) for single, first and consecutive frames, then registers the result.
// Throughput: one transfer per cycle into a 2-entry command queue while it is not full;
//   the back end and its single-port message store finish each item before the next.
// Reset: control cleared, configuration set to its reset values; message store has no reset
//   or clearing pass, reads are gated by the fill offset.
`default_nettype none
module isotp_rx_reassembler #(
    parameter int MAX_MESSAGE_BYTES = isotp_pkg::MAX_MESSAGE_BYTES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [19:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    // frame_id[28:0] frame_ext[29] frame_rtr[30] frame_dlc[34:31] payload[98:35]
    // now_ms[130:99] read_index[140:131]
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[2:0]
    output logic [2:0]        m_tuser,
    // read_data[7:0] msg_length[18:8] msg_complete[19] rx_active[20]
    output logic [23:0]       m_tdata
);
    isotp_pkg::cmd_t push_cmd, head_cmd;
    logic            q_full, q_push, q_pop, q_valid;

    isotp_front #(
        .MAX_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    isotp_cmdq #(
        .W ($bits(isotp_pkg::cmd_t))
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_cmd)
    );

    isotp_back #(
        .MAX_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire

// ===== hdl/isotp_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module isotp_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [2:0]  m_tuser,
    input wire logic [23:0] m_tdata
);
    logic        res_done;
    logic        res_act;
    logic [10:0] res_len;
    logic        is_complete;
    logic        is_expired;

    assign res_done    = m_tdata[19];
    assign res_act     = m_tdata[20];
    assign res_len     = m_tdata[18:8];
    assign is_complete = m_tvalid && (m_tuser == isotp_pkg::ST_COMPLETE);
    assign is_expired  = m_tvalid && (m_tuser == isotp_pkg::ST_EXPIRED);

    `CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
    `CHK_IMPL(a_status_range, m_tvalid, m_tuser <= isotp_pkg::ST_EXPIRED)
    `CHK_IMPL(a_complete_held, is_complete, res_done && !res_act)
    `CHK_IMPL(a_expired_clear, is_expired, !res_done && !res_act && (res_len == 11'd0))
endmodule

bind isotp_rx_reassembler isotp_chk u_chk (.*);
`default_nettype wire
